/* hdl/wsts_pkg.sv */
// Shared types, field widths and default sizes of the work-stealing task scheduler.
package wsts_pkg;

    // Fixed field widths of the stream and configuration ports.
    localparam int OP_W        = 3;
    localparam int THREAD_W    = 6;
    localparam int TASK_W      = 12;
    localparam int COUNT_W     = 8;
    localparam int ACT_W       = 7;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 16;

    // Default sizes of the queue and counter storage.
    localparam int DEF_MAX_THREADS = 64;
    localparam int DEF_MAX_TASKS   = 4096;
    localparam int DEF_QUEUE_DEPTH = 1024;

    // Value of the active thread count after reset.
    localparam logic [ACT_W-1:0] ACT_RESET = 7'd1;

    // Operation codes carried in the input transaction.
    typedef enum logic [OP_W-1:0] {
        OP_SET_COUNT   = 3'd0,
        OP_PUSH        = 3'd1,
        OP_ACT_PUSH    = 3'd2,
        OP_ACT_TAKE    = 3'd3,
        OP_ACT_ONE     = 3'd4,
        OP_GET_READY   = 3'd5,
        OP_STEAL       = 3'd6,
        OP_CLEAR_QUEUE = 3'd7
    } op_t;

endpackage

/* hdl/wsts_count_mem.sv */
// Activation counter memory with a clearing sweep after reset.
module wsts_count_mem
    import wsts_pkg::*;
#(
    parameter int MAX_TASKS = DEF_MAX_TASKS,
    localparam int IDX_W    = $clog2(MAX_TASKS)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rd_en,
    input  logic [IDX_W-1:0]   rd_addr,
    output logic [COUNT_W-1:0] rd_data,
    input  logic               wr_en,
    input  logic [IDX_W-1:0]   wr_addr,
    input  logic [COUNT_W-1:0] wr_data,
    output logic               busy
);

    logic [COUNT_W-1:0] mem [MAX_TASKS];
    logic [COUNT_W-1:0] rd_data_reg;
    logic               clr_busy_reg;
    logic [IDX_W-1:0]   clr_idx_reg;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_wa;
    logic [COUNT_W-1:0] mem_wd;

    // The sweep owns the write port until every counter is zero.
    assign mem_we = clr_busy_reg || wr_en;
    assign mem_wa = clr_busy_reg ? clr_idx_reg : wr_addr;
    assign mem_wd = clr_busy_reg ? '0 : wr_data;

    // Sweep counter, one entry per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
            if (clr_idx_reg == IDX_W'(MAX_TASKS - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // Single write port, single registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_busy_reg;

endmodule

/* hdl/work_stealing_task_scheduler_top.sv */
// Top level of the work-stealing task scheduler: sequencer, deque storage and stream ports.
// Usage:
//   Input transactions arrive on s_axis_* and carry one scheduler operation
//   (set count, push, three kinds of activation, get ready, steal, clear queue).
//   Every input transaction produces exactly one result transaction on m_axis_*
//   with the next task for the thread and the push and overflow flags.
//   cfg_wr_en/cfg_wr_data set the number of queues that a steal scans; write it
//   only while no operation is in flight.
// Timing:
//   The sequencer works on one operation at a time and drops s_axis_tready
//   while it does. The counter and pointer memories are read at the accepting
//   edge and most operations load the result register from S_EXEC, so the next
//   input can be taken only after the previous one has finished. A pop from a
//   queue head goes on to S_DATA for the task store read. A steal skips queues
//   in S_SCAN one per cycle (at most 63), then reads the victim's pointers in
//   S_SPTR and its task in S_DATA; a steal that finds nothing loads from S_SCAN.
// Reset and backpressure:
//   All queues are empty after reset; the counters are then zeroed by a sweep over all
//   MAX_TASKS entries during which no input transaction is taken. While m_axis_tready
//   is low a finished result waits in the output register and the sequencer holds.
module work_stealing_task_scheduler_top
    import wsts_pkg::*;
#(
    parameter int MAX_THREADS = DEF_MAX_THREADS,
    parameter int MAX_TASKS   = DEF_MAX_TASKS,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // From low bit: operation[2:0], thread[8:3], task_req[20:9],
    // count_value[28:21], current_task[40:29], zero padding.
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // From low bit: next_task[11:0], task_pushed[12], queue_overflow[13], zero padding.
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic                   cfg_wr_en,
    input  logic [ACT_W-1:0]       cfg_wr_data
);

    localparam int THR_W      = $clog2(MAX_THREADS);
    localparam int TASK_IDX_W = $clog2(MAX_TASKS);
    localparam int QD_W       = $clog2(QUEUE_DEPTH);
    localparam int FILL_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int PTR_W      = FILL_W + 2 * QD_W;
    localparam int STORE_AW   = THR_W + QD_W;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_SCAN = 5'b00100,
        S_SPTR = 5'b01000,
        S_DATA = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Unpacked input transaction.
    op_t                in_op;
    logic [THREAD_W-1:0] in_thread;
    logic [TASK_W-1:0]  in_task;
    logic [COUNT_W-1:0] in_count;
    logic [TASK_W-1:0]  in_cur;
    logic               s_fire;
    logic               out_free;

    // Latched operation.
    op_t                op_reg;
    logic [THREAD_W-1:0] thr_reg;
    logic [TASK_W-1:0]  task_reg;
    logic [COUNT_W-1:0] cnt_reg;
    logic [TASK_W-1:0]  cur_reg;

    logic [ACT_W-1:0]   active_reg;
    logic [ACT_W-1:0]   n_scan;
    logic [ACT_W-1:0]   scan_idx_reg, scan_idx_next;

    // Queue pointer memory, its valid bits and non-empty bits.
    logic [PTR_W-1:0]       ptr_mem [MAX_THREADS];
    logic [MAX_THREADS-1:0] ptr_vld_reg;
    logic [MAX_THREADS-1:0] nonempty_reg;
    logic [PTR_W-1:0]       ptr_rd_reg;
    logic                   ptr_rd_vld_reg;
    logic                   ptr_re, ptr_we;
    logic [THR_W-1:0]       ptr_ra, ptr_wa;
    logic [PTR_W-1:0]       ptr_wd;
    logic [PTR_W-1:0]       ptr_rd_eff;
    logic                   q_clear;

    logic [QD_W-1:0]   ptr_head, ptr_tail, head_inc, head_dec, tail_inc;
    logic [FILL_W-1:0] ptr_fill, fill_inc, fill_dec;

    // Task store.
    logic [TASK_W-1:0]   store_mem [MAX_THREADS * (2 ** QD_W)];
    logic [TASK_W-1:0]   store_rd_reg;
    logic                store_re, store_we;
    logic [STORE_AW-1:0] store_ra, store_wa;

    // Counter memory port.
    logic               cnt_busy;
    logic [COUNT_W-1:0] cnt_rd;
    logic [COUNT_W-1:0] cnt_dec;
    logic               cnt_we;
    logic [COUNT_W-1:0] cnt_wd;

    // Decisions of the execute step.
    logic             thr_ok, task_in_range, task_ok;
    logic             is_act, do_dec, became_ready, do_push, do_pop, q_full;
    logic [THR_W-1:0] q_exec, q_scan;

    // Output register.
    logic              m_valid_reg;
    logic [TASK_W-1:0] out_next_reg;
    logic              out_pushed_reg, out_ovf_reg;
    logic              out_load;
    logic [TASK_W-1:0] out_next_d;
    logic              out_pushed_d, out_ovf_d;

    // Input fields and handshakes.
    assign in_op     = op_t'(s_axis_tdata[2:0]);
    assign in_thread = s_axis_tdata[8:3];
    assign in_task   = s_axis_tdata[20:9];
    assign in_count  = s_axis_tdata[28:21];
    assign in_cur    = s_axis_tdata[40:29];

    assign s_axis_tready = (state_reg == S_IDLE) && !cnt_busy;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {2'b00, out_ovf_reg, out_pushed_reg, out_next_reg};

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= ACT_RESET;
        end
        else if (cfg_wr_en)
        begin
            active_reg <= cfg_wr_data;
        end
    end

    // Number of queues a steal looks at, saturated to the queue count.
    assign n_scan = (32'(active_reg) > 32'(MAX_THREADS)) ? ACT_W'(MAX_THREADS) : active_reg;

    // Latch the accepted operation.
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            op_reg   <= in_op;
            thr_reg  <= in_thread;
            task_reg <= in_task;
            cnt_reg  <= in_count;
            cur_reg  <= in_cur;
        end
    end

    // Activation counters.
    wsts_count_mem #(
        .MAX_TASKS (MAX_TASKS)
    ) u_count_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (s_fire),
        .rd_addr (TASK_IDX_W'(in_task)),
        .rd_data (cnt_rd),
        .wr_en   (cnt_we),
        .wr_addr (TASK_IDX_W'(task_reg)),
        .wr_data (cnt_wd),
        .busy    (cnt_busy)
    );

    // Pointer fields of the queue that was read; an unwritten queue reads as empty.
    assign ptr_rd_eff = ptr_rd_vld_reg ? ptr_rd_reg : '0;
    assign ptr_head   = ptr_rd_eff[QD_W-1:0];
    assign ptr_tail   = ptr_rd_eff[2*QD_W-1:QD_W];
    assign ptr_fill   = ptr_rd_eff[PTR_W-1:2*QD_W];

    // Ring arithmetic on the pointers.
    assign head_inc = (ptr_head == QD_W'(QUEUE_DEPTH - 1)) ? '0 : ptr_head + 1'b1;
    assign head_dec = (ptr_head == '0) ? QD_W'(QUEUE_DEPTH - 1) : ptr_head - 1'b1;
    assign tail_inc = (ptr_tail == QD_W'(QUEUE_DEPTH - 1)) ? '0 : ptr_tail + 1'b1;
    assign fill_inc = ptr_fill + 1'b1;
    assign fill_dec = ptr_fill - 1'b1;
    assign q_full   = (ptr_fill == FILL_W'(QUEUE_DEPTH));

    // Operation decode for the execute step.
    assign q_exec        = THR_W'(thr_reg);
    assign q_scan        = THR_W'(scan_idx_reg);
    assign thr_ok        = 32'(thr_reg) < 32'(MAX_THREADS);
    assign task_in_range = 32'(task_reg) < 32'(MAX_TASKS);
    assign task_ok       = (task_reg != '0) && task_in_range;
    assign is_act        = (op_reg == OP_ACT_PUSH) || (op_reg == OP_ACT_TAKE)
                           || (op_reg == OP_ACT_ONE);
    assign do_dec        = is_act && task_ok && (cnt_rd != '0);
    assign became_ready  = do_dec && (cnt_rd == COUNT_W'(1));
    assign cnt_dec       = cnt_rd - 1'b1;
    assign do_push       = ((op_reg == OP_PUSH) && task_ok)
                           || ((op_reg == OP_ACT_PUSH) && became_ready)
                           || ((op_reg == OP_ACT_TAKE) && became_ready && (cur_reg != '0));
    assign do_pop        = ((op_reg == OP_ACT_ONE) && !became_ready)
                           || ((op_reg == OP_GET_READY) && (cur_reg == '0));

    // Sequencer and memory port control.
    always_comb
    begin
        state_next    = state_reg;
        scan_idx_next = scan_idx_reg;
        ptr_re        = 1'b0;
        ptr_ra        = THR_W'(in_thread);
        ptr_we        = 1'b0;
        ptr_wa        = q_exec;
        ptr_wd        = '0;
        q_clear       = 1'b0;
        store_we      = 1'b0;
        store_wa      = {q_exec, ptr_head};
        store_re      = 1'b0;
        store_ra      = {q_exec, head_dec};
        cnt_we        = 1'b0;
        cnt_wd        = cnt_reg;
        out_load      = 1'b0;
        out_next_d    = cur_reg;
        out_pushed_d  = 1'b0;
        out_ovf_d     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_fire)
                begin
                    ptr_re        = 1'b1;
                    scan_idx_next = '0;
                    state_next    = (in_op == OP_STEAL) ? S_SCAN : S_EXEC;
                end
            end

            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                    out_load   = 1'b1;
                    if ((op_reg == OP_SET_COUNT) && task_in_range)
                    begin
                        cnt_we = 1'b1;
                    end
                    if (do_dec)
                    begin
                        cnt_we = 1'b1;
                        cnt_wd = cnt_dec;
                    end
                    if (became_ready && (op_reg == OP_ACT_ONE
                        || (op_reg == OP_ACT_TAKE && cur_reg == '0)))
                    begin
                        out_next_d = task_reg;
                    end
                    // Push at the head, or flag a full queue.
                    if (do_push && thr_ok)
                    begin
                        if (q_full)
                        begin
                            out_ovf_d = 1'b1;
                        end
                        else
                        begin
                            store_we     = 1'b1;
                            ptr_we       = 1'b1;
                            ptr_wd       = {fill_inc, ptr_tail, head_inc};
                            out_pushed_d = 1'b1;
                        end
                    end
                    // Pop at the head; the task arrives from the store next cycle.
                    if (do_pop)
                    begin
                        if (thr_ok && (ptr_fill != '0))
                        begin
                            out_load   = 1'b0;
                            state_next = S_DATA;
                            store_re   = 1'b1;
                            ptr_we     = 1'b1;
                            ptr_wd     = {fill_dec, ptr_tail, head_dec};
                        end
                        else
                        begin
                            out_next_d = '0;
                        end
                    end
                    if ((op_reg == OP_CLEAR_QUEUE) && thr_ok)
                    begin
                        q_clear = 1'b1;
                    end
                end
            end

            S_SCAN:
            begin
                ptr_ra = q_scan;
                if (scan_idx_reg >= n_scan)
                begin
                    // No victim found.
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        out_next_d = '0;
                        state_next = S_IDLE;
                    end
                end
                else if ((scan_idx_reg != ACT_W'(thr_reg)) && nonempty_reg[q_scan])
                begin
                    ptr_re     = 1'b1;
                    state_next = S_SPTR;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end

            S_SPTR:
            begin
                // Tail pop of the victim queue.
                ptr_we     = 1'b1;
                ptr_wa     = q_scan;
                ptr_wd     = {fill_dec, tail_inc, ptr_head};
                store_re   = 1'b1;
                store_ra   = {q_scan, ptr_tail};
                state_next = S_DATA;
            end

            S_DATA:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    out_next_d = store_rd_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer registers and per-queue status bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            scan_idx_reg   <= '0;
            ptr_vld_reg    <= '0;
            nonempty_reg   <= '0;
            ptr_rd_vld_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_idx_reg <= scan_idx_next;
            if (ptr_re)
            begin
                ptr_rd_vld_reg <= ptr_vld_reg[ptr_ra];
            end
            if (ptr_we)
            begin
                ptr_vld_reg[ptr_wa]  <= 1'b1;
                nonempty_reg[ptr_wa] <= (ptr_wd[PTR_W-1:2*QD_W] != '0);
            end
            if (q_clear)
            begin
                ptr_vld_reg[q_exec]  <= 1'b0;
                nonempty_reg[q_exec] <= 1'b0;
            end
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Pointer memory.
    always_ff @(posedge clk)
    begin
        if (ptr_we)
        begin
            ptr_mem[ptr_wa] <= ptr_wd;
        end
        if (ptr_re)
        begin
            ptr_rd_reg <= ptr_mem[ptr_ra];
        end
    end

    // Task store.
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[store_wa] <= task_reg;
        end
        if (store_re)
        begin
            store_rd_reg <= store_mem[store_ra];
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_next_reg   <= out_next_d;
            out_pushed_reg <= out_pushed_d;
            out_ovf_reg    <= out_ovf_d;
        end
    end

`ifndef SYNTHESIS
    a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_busy |-> !s_axis_tready)
        else $error("Input accepted during counter clearing sweep.");

    a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> !s_axis_tready)
        else $error("Second transaction accepted while an operation is in flight.");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> !(out_pushed_reg && out_ovf_reg))
        else $error("Result reports both a push and an overflow.");

    a_steal_victim_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SPTR) |-> (ptr_fill != '0))
        else $error("Steal selected a queue whose fill count is zero.");

    a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) |-> (ptr_fill <= FILL_W'(QUEUE_DEPTH)))
        else $error("Queue fill count exceeds queue depth.");
`endif

endmodule
